/* rtl/ppu_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the palette pixel pack/unpack unit.
package ppu_pkg;

    localparam int PACKED_BITS       = 8;
    localparam int MAX_REPEAT        = 8;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CNT_W             = $clog2(PACKED_BITS + 1);
    localparam int REP_W             = 4;
    localparam int COLOR_W           = 32;

    localparam logic REG_BPP_CODE     = 1'b0;
    localparam logic REG_PALETTE_SIZE = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_PACK   = 2'd1,
        OP_UNPACK = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_PACK   = 2'd1,
        CMD_UNPACK = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0] {
        RK_WORD   = 2'd0,
        RK_PIXEL  = 2'd1,
        RK_STATUS = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NOT_FOUND = 3'd1,
        STAT_IDX_WIDE  = 3'd2,
        STAT_IDX_RANGE = 3'd3,
        STAT_SHORT_RUN = 3'd4
    } status_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [7:0]             entry;
        logic [COLOR_W-1:0]     rgba;
        logic [PACKED_BITS-1:0] word;
        logic [REP_W-1:0]       reps;
        logic                   end_of_run;
    } cmd_t;

    // largest index that fits one pixel at the given depth code
    function automatic logic [7:0] pixel_max(input logic [1:0] code);
        logic [7:0] m;
        begin
            case (code)
                2'd0:    m = 8'd1;
                2'd1:    m = 8'd3;
                2'd2:    m = 8'd15;
                default: m = 8'd255;
            endcase
            return m;
        end
    endfunction

endpackage

/* rtl/palette_pixel_pack_unpack_unit.sv */
`timescale 1ns / 1ps
// Palette pixel pack/unpack unit: top level with APB registers, front end and back end.
//
// Input channel (item_valid/item_ready): palette writes, pack colours, unpack words.
// Result channel (result_valid/result_ready): packed words, pixel colours, error status;
// last marks the final result of an input transaction.
// APB port: bpp_code at 0x0, palette_size at 0x4; pready is tied high.
// A two-entry command queue separates the front end from the back end, so input
// transactions are taken while the back end works or a result waits.
// Palette write: written into the palette RAM once the back end is idle and takes it
// from the queue, no result.
// Pack: the palette search reads one entry per cycle from the palette RAM and stops at the
// first match; a result comes when the word fills, on an error, or at end_of_run.
// Unpack: one pixel per cycle while the receiver takes results, up to 64.
// One transaction is worked on at a time; the next starts once the back end has finished it.
// Reset clears the queue, the accumulator and the result register, and sets
// bpp_code to 0 and palette_size to 256; palette contents are undefined until written.
// When the receiver stalls, the result register holds, the back end waits and the
// queue fills; item_ready drops once two commands are queued.
module palette_pixel_pack_unpack_unit
    import ppu_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [1:0]       operation,
    input  logic [7:0]       entry_index,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [7:0]       alpha,
    input  logic [7:0]       packed_in,
    input  logic [REP_W-1:0] repeat_times,
    input  logic             end_of_run,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [1:0]       result_kind,
    output logic [7:0]       packed_out,
    output logic [7:0]       out_red,
    output logic [7:0]       out_green,
    output logic [7:0]       out_blue,
    output logic [7:0]       out_alpha,
    output logic [2:0]       status,
    output logic             last
);

    logic [1:0] bpp_code_reg, bpp_code_next;
    logic [8:0] palette_size_reg, palette_size_next;
    logic       reg_wr;
    logic       reg_sel;
    logic       cmd_valid;
    logic       cmd_pop;
    cmd_t       cmd;

    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        bpp_code_next     = bpp_code_reg;
        palette_size_next = palette_size_reg;
        if (reg_wr)
        begin
            unique case (reg_sel)
                REG_BPP_CODE:     bpp_code_next     = pwdata[1:0];
                REG_PALETTE_SIZE: palette_size_next = pwdata[8:0];
                default:          bpp_code_next     = bpp_code_reg;
            endcase
        end
    end

    assign prdata = (reg_sel == REG_PALETTE_SIZE) ? 32'(palette_size_reg) : 32'(bpp_code_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_code_reg     <= 2'd0;
            palette_size_reg <= 9'd256;
        end
        else
        begin
            bpp_code_reg     <= bpp_code_next;
            palette_size_reg <= palette_size_next;
        end
    end

    ppu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .entry_index  (entry_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .packed_in    (packed_in),
        .repeat_times (repeat_times),
        .end_of_run   (end_of_run),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop)
    );

    ppu_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .bpp_code     (bpp_code_reg),
        .palette_size (palette_size_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_kind  (result_kind),
        .packed_out   (packed_out),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .status       (status),
        .last         (last)
    );

endmodule

/* rtl/ppu_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ppu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/ppu_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them and queues commands.
module ppu_front
    import ppu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [1:0]             operation,
    input  logic [7:0]             entry_index,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  logic [7:0]             alpha,
    input  logic [7:0]             packed_in,
    input  logic [REP_W-1:0]       repeat_times,
    input  logic                   end_of_run,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  logic                   cmd_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic              accept;
    logic              push;
    cmd_t              cmd_in;
    op_t               op;
    logic [REP_W-1:0]  reps_clamped;

    assign item_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign accept     = item_valid && item_ready;
    assign op         = op_t'(operation);

    assign reps_clamped = (repeat_times > REP_W'(MAX_REPEAT)) ? REP_W'(MAX_REPEAT)
                                                               : repeat_times;

    // unknown operations and zero-repeat unpacks are dropped here
    always_comb
    begin
        cmd_in.kind       = CMD_WRITE;
        cmd_in.entry      = entry_index;
        cmd_in.rgba       = {red, green, blue, alpha};
        cmd_in.word       = PACKED_BITS'(packed_in);
        cmd_in.reps       = reps_clamped;
        cmd_in.end_of_run = end_of_run;
        push              = 1'b0;
        unique case (op)
            OP_WRITE:
            begin
                cmd_in.kind = CMD_WRITE;
                push        = accept;
            end
            OP_PACK:
            begin
                cmd_in.kind = CMD_PACK;
                push        = accept;
            end
            OP_UNPACK:
            begin
                cmd_in.kind = CMD_UNPACK;
                push        = accept && (repeat_times != '0);
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* rtl/ppu_back.sv */
`timescale 1ns / 1ps
// Back end: palette store, search, pack accumulator, unpack sequencer, result register.
module ppu_back
    import ppu_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_pop,
    input  logic [1:0] bpp_code,
    input  logic [8:0] palette_size,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [1:0] result_kind,
    output logic [7:0] packed_out,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic [2:0] status,
    output logic       last
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PACK,
        S_UCHECK,
        S_UEMIT
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [CW-1:0]          scan_reg, scan_next;
    logic                   rdv_reg, rdv_next;
    logic [AW-1:0]          cmpidx_reg, cmpidx_next;
    logic                   found_reg, found_next;
    logic [AW-1:0]          fidx_reg, fidx_next;
    logic [PACKED_BITS-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       pix_reg, pix_next;
    logic [REP_W-1:0]       rep_reg, rep_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_kind_reg, out_kind_next;
    logic [7:0]             out_word_reg, out_word_next;
    logic [COLOR_W-1:0]     out_rgba_reg, out_rgba_next;
    logic [2:0]             out_status_reg, out_status_next;
    logic                   out_last_reg, out_last_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [COLOR_W-1:0]     ram_rdata;

    logic [CW-1:0]          nvalid;
    logic [CNT_W-1:0]       per_word;
    logic                   can_put;

    logic                   em;
    result_kind_t           em_kind;
    logic [7:0]             em_word;
    logic [COLOR_W-1:0]     em_rgba;
    status_t                em_status;
    logic                   em_last;

    logic [7:0]             idx8;
    logic                   pk_err;
    logic [CNT_W-1:0]       pk_c0, pk_c1;
    logic [PACKED_BITS-1:0] pk_a0, pk_a1;

    logic [7:0]             cur_idx, nxt_idx;
    logic                   cur_ovr, nxt_ovr;
    logic                   pix_wrap, u_final;
    logic [CNT_W-1:0]       pix_adv;
    logic [REP_W-1:0]       rep_adv;

    function automatic logic [7:0] slot_shift(input logic [1:0] code,
                                              input logic [CNT_W-1:0] slot);
        logic [7:0] used;
        begin
            used = 8'(slot) + 8'd1;
            used = used << code;
            return 8'(PACKED_BITS) - used;
        end
    endfunction

    function automatic logic [7:0] pixel_at(input logic [PACKED_BITS-1:0] word,
                                            input logic [1:0] code,
                                            input logic [CNT_W-1:0] slot);
        logic [PACKED_BITS-1:0] sh;
        begin
            sh = word >> slot_shift(code, slot);
            return 8'(sh) & pixel_max(code);
        end
    endfunction

    ppu_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.rgba),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nvalid   = (palette_size > 9'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                         : CW'(palette_size);
    assign per_word = CNT_W'(PACKED_BITS >> bpp_code);
    assign can_put  = !out_valid_reg || result_ready;

    assign ram_we    = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == CMD_WRITE)
                       && ({1'b0, cmd.entry} < 9'(PALETTE_DEPTH));
    assign ram_waddr = cmd.entry[AW-1:0];

    // pack placement
    assign idx8   = 8'(fidx_reg);
    assign pk_err = !found_reg || (idx8 > pixel_max(bpp_code));
    assign pk_c0  = (cnt_reg >= per_word) ? '0 : cnt_reg;
    assign pk_a0  = (cnt_reg >= per_word) ? '0 : acc_reg;
    assign pk_a1  = pk_a0 | (PACKED_BITS'(idx8) << slot_shift(bpp_code, pk_c0));
    assign pk_c1  = pk_c0 + 1'b1;

    // unpack sequencing
    assign pix_wrap = (pix_reg == per_word - 1'b1);
    assign pix_adv  = pix_wrap ? '0 : pix_reg + 1'b1;
    assign rep_adv  = pix_wrap ? rep_reg + 1'b1 : rep_reg;
    assign u_final  = pix_wrap && (rep_reg == cmd_reg.reps - 1'b1);
    assign cur_idx  = pixel_at(cmd_reg.word, bpp_code, pix_reg);
    assign nxt_idx  = pixel_at(cmd_reg.word, bpp_code, pix_adv);
    assign cur_ovr  = ({1'b0, cur_idx} >= 9'(nvalid));
    assign nxt_ovr  = ({1'b0, nxt_idx} >= 9'(nvalid));

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        scan_next   = scan_reg;
        rdv_next    = rdv_reg;
        cmpidx_next = cmpidx_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        pix_next    = pix_reg;
        rep_next    = rep_reg;
        cmd_pop     = 1'b0;
        ram_raddr   = cur_idx[AW-1:0];
        em          = 1'b0;
        em_kind     = RK_STATUS;
        em_word     = '0;
        em_rgba     = '0;
        em_status   = STAT_OK;
        em_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    case (cmd.kind)
                        CMD_PACK:
                        begin
                            scan_next  = '0;
                            rdv_next   = 1'b0;
                            state_next = S_SEARCH;
                        end
                        CMD_UNPACK:
                        begin
                            pix_next   = '0;
                            rep_next   = '0;
                            state_next = S_UCHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                ram_raddr = scan_reg[AW-1:0];
                if (rdv_reg && (ram_rdata == cmd_reg.rgba))
                begin
                    found_next = 1'b1;
                    fidx_next  = cmpidx_reg;
                    state_next = S_PACK;
                end
                else if (scan_reg < nvalid)
                begin
                    rdv_next    = 1'b1;
                    cmpidx_next = scan_reg[AW-1:0];
                    scan_next   = scan_reg + 1'b1;
                end
                else if (!rdv_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_PACK;
                end
                else
                begin
                    rdv_next = 1'b0;
                end
            end
            S_PACK:
            begin
                if (can_put)
                begin
                    state_next = S_IDLE;
                    if (pk_err)
                    begin
                        em        = 1'b1;
                        em_kind   = RK_STATUS;
                        em_status = found_reg ? STAT_IDX_WIDE : STAT_NOT_FOUND;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                    else if (pk_c1 >= per_word)
                    begin
                        em       = 1'b1;
                        em_kind  = RK_WORD;
                        em_word  = 8'(pk_a1);
                        acc_next = '0;
                        cnt_next = '0;
                    end
                    else if (cmd_reg.end_of_run)
                    begin
                        em        = 1'b1;
                        em_kind   = RK_STATUS;
                        em_status = STAT_SHORT_RUN;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        acc_next = pk_a1;
                        cnt_next = pk_c1;
                    end
                end
            end
            S_UCHECK:
            begin
                if (cur_ovr)
                begin
                    if (can_put)
                    begin
                        em         = 1'b1;
                        em_kind    = RK_STATUS;
                        em_status  = STAT_IDX_RANGE;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_UEMIT;
                end
            end
            S_UEMIT:
            begin
                if (can_put)
                begin
                    em      = 1'b1;
                    em_kind = RK_PIXEL;
                    em_rgba = ram_rdata;
                    em_last = u_final;
                    if (u_final)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pix_next  = pix_adv;
                        rep_next  = rep_adv;
                        ram_raddr = nxt_idx[AW-1:0];
                        if (nxt_ovr)
                        begin
                            state_next = S_UCHECK;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg && !result_ready;
        out_kind_next   = out_kind_reg;
        out_word_next   = out_word_reg;
        out_rgba_next   = out_rgba_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (em)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = em_kind;
            out_word_next   = em_word;
            out_rgba_next   = em_rgba;
            out_status_next = em_status;
            out_last_next   = em_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            scan_reg       <= '0;
            rdv_reg        <= 1'b0;
            cmpidx_reg     <= '0;
            found_reg      <= 1'b0;
            fidx_reg       <= '0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            pix_reg        <= '0;
            rep_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= '0;
            out_word_reg   <= '0;
            out_rgba_reg   <= '0;
            out_status_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            scan_reg       <= scan_next;
            rdv_reg        <= rdv_next;
            cmpidx_reg     <= cmpidx_next;
            found_reg      <= found_next;
            fidx_reg       <= fidx_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            pix_reg        <= pix_next;
            rep_reg        <= rep_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_word_reg   <= out_word_next;
            out_rgba_reg   <= out_rgba_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign packed_out   = out_word_reg;
    assign out_red      = out_rgba_reg[31:24];
    assign out_green    = out_rgba_reg[23:16];
    assign out_blue     = out_rgba_reg[15:8];
    assign out_alpha    = out_rgba_reg[7:0];
    assign status       = out_status_reg;
    assign last         = out_last_reg;

endmodule

/* tb/palette_pixel_pack_unpack_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the palette pixel pack/unpack unit.
module palette_pixel_pack_unpack_unit_tb
    import ppu_pkg::*;
;

    localparam int RESULT_LIMIT  = 64;
    localparam int SETTLE_CYCLES = 1000;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        op_t        op;
        logic [7:0] entry;
        logic [31:0] rgba;
        logic [7:0] word;
        logic [3:0] reps;
        logic       eor;
    } pixel_item_t;

    typedef struct {
        result_kind_t kind;
        logic [7:0]   word;
        logic [31:0]  rgba;
        status_t      stat;
        logic         last;
    } conv_result_t;

    typedef enum {ROW_REG, ROW_ITEM, ROW_TYPED} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic         reg_sel;
        logic [8:0]   reg_val;
        pixel_item_t  item;
        conv_result_t want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  operation = '0;
    logic [7:0]  entry_index = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic [7:0]  alpha = '0;
    logic [7:0]  packed_in = '0;
    logic [REP_W-1:0] repeat_times = '0;
    logic        end_of_run = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  result_kind;
    logic [7:0]  packed_out;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [2:0]  status;
    logic        last;

    // mirror of the block's state
    logic [31:0] pal_mirror [256];
    bit          pal_written [256];
    logic [7:0]  acc_mirror;
    int unsigned acc_count;
    logic [1:0]  bpp_mirror;
    logic [8:0]  psize_mirror;

    conv_result_t step_results[$];
    conv_result_t conv_results_q[$];
    row_t         dir_tab[$];
    int           errors = 0;
    bit           no_gaps = 1'b0;
    int unsigned  cycle_count = 0;

    palette_pixel_pack_unpack_unit uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready),
        .operation(operation), .entry_index(entry_index),
        .red(red), .green(green), .blue(blue), .alpha(alpha),
        .packed_in(packed_in), .repeat_times(repeat_times), .end_of_run(end_of_run),
        .result_valid(result_valid), .result_ready(result_ready),
        .result_kind(result_kind), .packed_out(packed_out),
        .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
        .out_alpha(out_alpha), .status(status), .last(last)
    );

    always #2 clk = ~clk;

    task automatic add_result(input result_kind_t k, input logic [7:0] w,
                              input logic [31:0] rgba, input status_t s);
        conv_result_t r;
        r = '{k, w, rgba, s, 1'b0};
        step_results.push_back(r);
    endtask

    // works out the results of one accepted transaction and updates the mirror
    task automatic predict_conversion(input pixel_item_t it);
        int unsigned bpp, per_word, nvalid, idx, reps, i, r, p;
        bit          found, stop;
        logic [7:0]  pmask;
        step_results.delete();
        bpp      = 1 << bpp_mirror;
        per_word = PACKED_BITS / bpp;
        nvalid   = (psize_mirror > 256) ? 256 : psize_mirror;
        case (it.op)
            OP_WRITE:
            begin
                pal_mirror[it.entry]  = it.rgba;
                pal_written[it.entry] = 1'b1;
            end
            OP_PACK:
            begin
                found = 1'b0;
                idx   = 0;
                for (i = 0; i < nvalid && !found; i++)
                begin
                    if (pal_mirror[i] == it.rgba)
                    begin
                        found = 1'b1;
                        idx   = i;
                    end
                end
                if (!found || idx > (1 << bpp) - 1)
                begin
                    acc_mirror = '0;
                    acc_count  = 0;
                    add_result(RK_STATUS, 8'h00, 32'h0, found ? STAT_IDX_WIDE : STAT_NOT_FOUND);
                end
                else
                begin
                    if (acc_count >= per_word)
                    begin
                        acc_mirror = '0;
                        acc_count  = 0;
                    end
                    acc_mirror = acc_mirror | 8'(idx << (PACKED_BITS - bpp * (acc_count + 1)));
                    acc_count++;
                    if (acc_count >= per_word)
                    begin
                        add_result(RK_WORD, acc_mirror, 32'h0, STAT_OK);
                        acc_mirror = '0;
                        acc_count  = 0;
                    end
                    else if (it.eor)
                    begin
                        acc_mirror = '0;
                        acc_count  = 0;
                        add_result(RK_STATUS, 8'h00, 32'h0, STAT_SHORT_RUN);
                    end
                end
            end
            OP_UNPACK:
            begin
                reps  = (it.reps > MAX_REPEAT) ? MAX_REPEAT : it.reps;
                pmask = 8'((1 << bpp) - 1);
                stop  = 1'b0;
                for (r = 0; r < reps && !stop; r++)
                begin
                    for (p = 0; p < per_word && !stop; p++)
                    begin
                        if (step_results.size() >= RESULT_LIMIT)
                            stop = 1'b1;
                        else
                        begin
                            idx = (it.word >> (PACKED_BITS - bpp * (p + 1))) & pmask;
                            if (idx >= nvalid)
                            begin
                                add_result(RK_STATUS, 8'h00, 32'h0, STAT_IDX_RANGE);
                                stop = 1'b1;
                            end
                            else
                                add_result(RK_PIXEL, 8'h00, pal_mirror[idx], STAT_OK);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (step_results.size() != 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endtask

    task automatic send_item(input pixel_item_t it, input bit typed_row,
                             input conv_result_t want);
        int unsigned gap;
        gap = 0;
        if (!no_gaps)
            while ($urandom_range(99) < 17)
                gap++;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        operation    <= it.op;
        entry_index  <= it.entry;
        red          <= it.rgba[31:24];
        green        <= it.rgba[23:16];
        blue         <= it.rgba[15:8];
        alpha        <= it.rgba[7:0];
        packed_in    <= it.word;
        repeat_times <= it.reps;
        end_of_run   <= it.eor;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_conversion(it);
        if (typed_row)
            conv_results_q.push_back(want);
        else
            foreach (step_results[k])
                conv_results_q.push_back(step_results[k]);
    endtask

    // register writes only once the block has drained
    task automatic write_reg(input logic sel, input logic [8:0] val);
        item_valid <= 1'b0;
        while (conv_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_BPP_CODE)
            bpp_mirror = val[1:0];
        else
            psize_mirror = val;
    endtask

    function automatic pixel_item_t noise_item();
        pixel_item_t it;
        it.op    = OP_NONE;
        it.entry = 8'($urandom);
        it.rgba  = $urandom;
        it.word  = 8'($urandom);
        it.reps  = 4'($urandom_range(15));
        it.eor   = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic row_t item_row(input op_t op, input logic [7:0] entry,
                                      input logic [31:0] rgba, input logic [7:0] word,
                                      input logic [3:0] reps, input logic eor);
        row_t r;
        r.kind    = ROW_ITEM;
        r.reg_sel = REG_BPP_CODE;
        r.reg_val = '0;
        r.item    = '{op, entry, rgba, word, reps, eor};
        r.want    = '{RK_WORD, 8'h00, 32'h0, STAT_OK, 1'b1};
        return r;
    endfunction

    function automatic row_t reg_row(input logic sel, input logic [8:0] val);
        row_t r;
        r         = item_row(OP_NONE, 8'h00, 32'h0, 8'h00, 4'd0, 1'b0);
        r.kind    = ROW_REG;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic row_t with_result(input row_t r, input result_kind_t k,
                                         input logic [7:0] w, input status_t s);
        r.kind = ROW_TYPED;
        r.want = '{k, w, 32'h0, s, 1'b1};
        return r;
    endfunction

    task automatic run_phase(input logic [1:0] bpp, input logic [8:0] psize, input int count);
        int unsigned eff, fit, per_word, len, roll, e, k, p;
        int          sent;
        bit          broken;
        pixel_item_t it;
        conv_result_t none;
        none = '{RK_WORD, 8'h00, 32'h0, STAT_OK, 1'b0};
        eff  = (psize > 256) ? 256 : psize;
        for (e = 0; e < eff; e++)
        begin
            if (!pal_written[e])
            begin
                it       = noise_item();
                it.op    = OP_WRITE;
                it.entry = 8'(e);
                if (e != 0 && $urandom_range(3) == 0)
                    it.rgba = pal_mirror[$urandom_range(e - 1)];
                send_item(it, 1'b0, none);
            end
        end
        write_reg(REG_BPP_CODE, 9'(bpp));
        write_reg(REG_PALETTE_SIZE, psize);
        per_word = PACKED_BITS >> bpp;
        fit      = (eff < (1 << (1 << bpp))) ? eff : (1 << (1 << bpp));
        sent     = 0;
        while (sent < count)
        begin
            roll = $urandom_range(99);
            it   = noise_item();
            if (roll < 55)
            begin
                // pack run: mostly whole words, some cut short by end_of_run
                broken = ($urandom_range(4) == 0);
                len    = broken ? $urandom_range(1, per_word) : per_word;
                for (k = 0; k < len; k++)
                begin
                    it    = noise_item();
                    it.op = OP_PACK;
                    if (fit != 0 && $urandom_range(11) != 0)
                        it.rgba = pal_mirror[$urandom_range(fit - 1)];
                    else if (eff != 0 && $urandom_range(1) == 0)
                        it.rgba = pal_mirror[$urandom_range(eff - 1)];
                    if (k != len - 1)
                        it.eor = 1'b0;
                    else if (broken)
                        it.eor = 1'b1;
                    send_item(it, 1'b0, none);
                    sent++;
                end
            end
            else if (roll < 80)
            begin
                it.op = OP_UNPACK;
                if (fit != 0 && $urandom_range(4) != 0)
                begin
                    it.word = '0;
                    for (p = 0; p < per_word; p++)
                        it.word = 8'((it.word << (1 << bpp)) | $urandom_range(fit - 1));
                end
                send_item(it, 1'b0, none);
                sent++;
            end
            else if (roll < 92)
            begin
                it.op = OP_WRITE;
                if (eff != 0 && $urandom_range(1) == 0)
                    it.rgba = pal_mirror[$urandom_range(eff - 1)];
                send_item(it, 1'b0, none);
                sent++;
            end
            else
                send_item(it, 1'b0, none);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_sink
        conv_result_t want;
        result_ready <= no_gaps || ($urandom_range(99) >= 17);
        if (rst_n && result_valid && result_ready)
        begin
            if (conv_results_q.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d expected none", $time, result_kind);
                errors++;
            end
            else
            begin
                want = conv_results_q.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(result_kind));
                check_field("packed_out", 32'(want.word), 32'(packed_out));
                check_field("out_red", 32'(want.rgba[31:24]), 32'(out_red));
                check_field("out_green", 32'(want.rgba[23:16]), 32'(out_green));
                check_field("out_blue", 32'(want.rgba[15:8]), 32'(out_blue));
                check_field("out_alpha", 32'(want.rgba[7:0]), 32'(out_alpha));
                check_field("status", 32'(want.stat), 32'(status));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("palette_pixel_pack_unpack_unit_tb: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] c0, c1, c2, miss;
        c0   = 32'h0000_0000;
        c1   = 32'hFFFF_FFFF;
        c2   = 32'h1122_3344;
        miss = 32'h1234_5678;
        foreach (pal_mirror[i])
        begin
            pal_mirror[i]  = '0;
            pal_written[i] = 1'b0;
        end
        acc_mirror   = '0;
        acc_count    = 0;
        bpp_mirror   = 2'd0;
        psize_mirror = 9'd256;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part; bpp_code stays at its reset value until later
        dir_tab.push_back(reg_row(REG_PALETTE_SIZE, 9'd4));
        dir_tab.push_back(item_row(OP_WRITE, 8'd0, c0, 8'h00, 4'd1, 1'b0));
        dir_tab.push_back(item_row(OP_WRITE, 8'd1, c1, 8'h00, 4'd1, 1'b0));
        dir_tab.push_back(item_row(OP_WRITE, 8'd2, c2, 8'h00, 4'd1, 1'b0));
        dir_tab.push_back(item_row(OP_WRITE, 8'd3, c2, 8'h00, 4'd1, 1'b0));
        dir_tab.push_back(item_row(OP_PACK, 8'd0, c1, 8'h00, 4'd1, 1'b0));
        repeat (6) dir_tab.push_back(item_row(OP_PACK, 8'd0, c0, 8'h00, 4'd1, 1'b0));
        dir_tab.push_back(with_result(item_row(OP_PACK, 8'd0, c1, 8'h00, 4'd1, 1'b0),
                                      RK_WORD, 8'h81, STAT_OK));
        dir_tab.push_back(with_result(item_row(OP_PACK, 8'd0, c2, 8'h00, 4'd1, 1'b0),
                                      RK_STATUS, 8'h00, STAT_IDX_WIDE));
        dir_tab.push_back(with_result(item_row(OP_PACK, 8'd0, miss, 8'h00, 4'd1, 1'b0),
                                      RK_STATUS, 8'h00, STAT_NOT_FOUND));
        dir_tab.push_back(with_result(item_row(OP_PACK, 8'd0, c1, 8'h00, 4'd1, 1'b1),
                                      RK_STATUS, 8'h00, STAT_SHORT_RUN));
        dir_tab.push_back(item_row(OP_UNPACK, 8'd0, c0, 8'h00, 4'd8, 1'b0));
        dir_tab.push_back(item_row(OP_UNPACK, 8'd0, c0, 8'hA5, 4'd0, 1'b0));
        dir_tab.push_back(item_row(OP_UNPACK, 8'd0, c0, 8'h5A, 4'd15, 1'b0));
        dir_tab.push_back(item_row(OP_NONE, 8'd7, c1, 8'hFF, 4'd3, 1'b1));
        dir_tab.push_back(item_row(OP_PACK, 8'd0, c1, 8'h00, 4'd1, 1'b0));
        dir_tab.push_back(item_row(OP_PACK, 8'd0, c0, 8'h00, 4'd1, 1'b0));
        dir_tab.push_back(item_row(OP_PACK, 8'd0, c1, 8'h00, 4'd1, 1'b0));
        // partial word is dropped when the depth change leaves it already full
        dir_tab.push_back(reg_row(REG_BPP_CODE, 9'd3));
        dir_tab.push_back(with_result(item_row(OP_PACK, 8'd0, c2, 8'h00, 4'd1, 1'b0),
                                      RK_WORD, 8'h02, STAT_OK));
        dir_tab.push_back(reg_row(REG_BPP_CODE, 9'd2));
        dir_tab.push_back(with_result(item_row(OP_UNPACK, 8'd0, c0, 8'hF0, 4'd1, 1'b0),
                                      RK_STATUS, 8'h00, STAT_IDX_RANGE));
        dir_tab.push_back(item_row(OP_UNPACK, 8'd0, c0, 8'h3F, 4'd2, 1'b0));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_REG)
                write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
            else
                send_item(dir_tab[i].item, dir_tab[i].kind == ROW_TYPED, dir_tab[i].want);
        end

        run_phase(2'd0, 9'd2, 18);
        no_gaps = 1'b1;
        run_phase(2'd1, 9'd5, 20);
        no_gaps = 1'b0;
        run_phase(2'd2, 9'd16, 20);
        run_phase(2'd3, 9'd1, 10);
        run_phase(2'd0, 9'd0, 8);
        run_phase(2'd2, 9'd256, 20);
        run_phase(2'd3, 9'd511, 14);
        run_phase(2'd1, 9'd3, 12);

        item_valid <= 1'b0;
        while (conv_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("palette_pixel_pack_unpack_unit_tb: PASS");
        else
            $display("palette_pixel_pack_unpack_unit_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/ppu_pkg.sv
rtl/ppu_ram.sv
rtl/ppu_front.sv
rtl/ppu_back.sv
rtl/palette_pixel_pack_unpack_unit.sv
tb/palette_pixel_pack_unpack_unit_tb.sv
